/* rtl/rau_pkg.sv */
package rau_pkg;

  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned WIDE_WIDTH = 66;
  localparam int unsigned CNT_WIDTH = $clog2(WIDE_WIDTH + 1);

  typedef logic [WIDE_WIDTH-1:0] wide_t;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_LT  = 3'd4;
  localparam logic [2:0] OP_EQ  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam wide_t LIMIT = wide_t'((66'd1 << (WORD_WIDTH - 1)) - 66'd1);

endpackage

/* rtl/rau_divider.sv */
module rau_divider (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  rau_pkg::wide_t  dividend,
  input  rau_pkg::wide_t  divisor,
  output rau_pkg::wide_t  quotient,
  output rau_pkg::wide_t  remainder,
  output logic            busy,
  output logic            done
);

  logic [rau_pkg::CNT_WIDTH-1:0] cnt_r, cnt_nxt;
  rau_pkg::wide_t q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  rau_pkg::wide_t shifted;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {r_r[rau_pkg::WIDE_WIDTH-2:0], q_r[rau_pkg::WIDE_WIDTH-1]};
    if (start && !busy_r) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = rau_pkg::CNT_WIDTH'(rau_pkg::WIDE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= d_r) begin
        r_nxt = shifted - d_r;
        q_nxt = {q_r[rau_pkg::WIDE_WIDTH-2:0], 1'b1};
      end else begin
        r_nxt = shifted;
        q_nxt = {q_r[rau_pkg::WIDE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rau_pkg::CNT_WIDTH'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign quotient = q_r;
  assign remainder = r_r;
  assign busy = busy_r;
  assign done = done_r;

`ifndef NO_ASSERTIONS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy) else $error("done while busy");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> cnt_r == '0) else $error("counter left over");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held");
`endif

endmodule

/* rtl/rational_arithmetic_unit.sv */
// Each item runs the Euclid GCD steps for both operands and, for add, sub, mul and div,
// for the result, all on the one shared 66-bit restoring divider. Zero-denominator and
// undefined requests answer in the cycle after acceptance.
// Throughput: one item at a time; in_stall is high from acceptance until the result
// word is taken. Reset (rst_n low, synchronous) returns the sequencer to idle and
// clears the output valid; data registers are not reset.
module rational_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic signed [31:0] in_left_num,
  input  logic signed [31:0] in_left_den,
  input  logic signed [31:0] in_right_num,
  input  logic signed [31:0] in_right_den,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_result_num,
  output logic [30:0] out_result_den,
  output logic        out_compare_true,
  output logic [1:0]  out_status
);

  localparam int unsigned W = rau_pkg::WIDE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_GCD, S_QN, S_QD, S_NEXT, S_MUL1, S_MUL2, S_MUL3, S_OUT
  } state_t;

  state_t state_r;
  rau_pkg::wide_t an_r, ad_r, cn_r, cd_r;
  logic an_neg_r, cn_neg_r, rn_neg_r;
  rau_pkg::wide_t rn_r, rd_r;
  rau_pkg::wide_t ga_r, gb_r;
  logic [1:0] which_r;
  logic [2:0] op_r;
  rau_pkg::wide_t p1_r, p2_r;
  logic p1_neg_r, p2_neg_r;
  logic signed [31:0] o_num_r;
  logic [30:0] o_den_r;
  logic o_cmp_r;
  logic [1:0] o_st_r;
  logic out_valid_r;

  logic div_start, div_busy, div_done;
  rau_pkg::wide_t div_a, div_b, div_q, div_r;

  rau_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .quotient(div_q), .remainder(div_r), .busy(div_busy), .done(div_done)
  );

  function automatic rau_pkg::wide_t magw(input logic signed [31:0] v);
    logic signed [W-1:0] e;
    e = W'(v);
    return e[W-1] ? rau_pkg::wide_t'(-e) : rau_pkg::wide_t'(e);
  endfunction

  rau_pkg::wide_t cur_n, cur_d;
  always_comb begin
    unique case (which_r)
      2'd0: begin cur_n = an_r; cur_d = ad_r; end
      2'd1: begin cur_n = cn_r; cur_d = cd_r; end
      default: begin cur_n = rn_r; cur_d = rd_r; end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_a = ga_r;
    div_b = gb_r;
    unique case (state_r)
      S_GCD: div_start = !div_busy && !div_done && gb_r != '0;
      S_QN: begin
        div_a = cur_n; div_b = ga_r; div_start = !div_busy && !div_done;
      end
      S_QD: begin
        div_a = cur_d; div_b = ga_r; div_start = !div_busy && !div_done;
      end
      default: ;
    endcase
  end

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    mul_a = an_r[31:0];
    mul_b = cd_r[31:0];
    if (state_r == S_MUL2) begin
      mul_a = cn_r[31:0]; mul_b = ad_r[31:0];
    end else if (state_r == S_MUL3) begin
      mul_a = ad_r[31:0];
    end else if (op_r == rau_pkg::OP_MUL) begin
      mul_b = cn_r[31:0];
    end
    prod = mul_a * mul_b;
  end

  logic signed [W+1:0] s1, s2, sres;
  always_comb begin
    s1 = p1_neg_r ? -$signed({2'b0, p1_r}) : $signed({2'b0, p1_r});
    s2 = p2_neg_r ? -$signed({2'b0, p2_r}) : $signed({2'b0, p2_r});
    sres = (op_r == rau_pkg::OP_SUB) ? s1 - s2 : s1 + s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_req_type;
            an_r <= magw(in_left_num);
            ad_r <= magw(in_left_den);
            cn_r <= magw(in_right_num);
            cd_r <= magw(in_right_den);
            an_neg_r <= in_left_num[31] ^ in_left_den[31];
            cn_neg_r <= in_right_num[31] ^ in_right_den[31];
            o_num_r <= '0; o_cmp_r <= 1'b0;
            if (in_req_type > rau_pkg::OP_EQ) begin
              o_den_r <= 31'd1; o_st_r <= rau_pkg::ST_OK;
              state_r <= S_OUT; out_valid_r <= 1'b1;
            end else if (in_left_den == '0 || in_right_den == '0) begin
              o_den_r <= '0; o_st_r <= rau_pkg::ST_ZERO_DEN;
              state_r <= S_OUT; out_valid_r <= 1'b1;
            end else begin
              o_den_r <= 31'd1; o_st_r <= rau_pkg::ST_OK;
              which_r <= 2'd0;
              state_r <= S_NORM;
            end
          end
        end
        S_NORM: begin
          ga_r <= cur_n; gb_r <= cur_d;
          state_r <= S_GCD;
        end
        S_GCD: begin
          if (gb_r == '0) begin
            if (ga_r == '0) ga_r <= rau_pkg::wide_t'(1);
            state_r <= S_QN;
          end else if (div_done) begin
            ga_r <= gb_r; gb_r <= div_r;
          end
        end
        S_QN: if (div_done) begin
          unique case (which_r)
            2'd0: an_r <= div_q;
            2'd1: cn_r <= div_q;
            default: rn_r <= div_q;
          endcase
          state_r <= S_QD;
        end
        S_QD: if (div_done) begin
          unique case (which_r)
            2'd0: ad_r <= div_q;
            2'd1: cd_r <= div_q;
            default: rd_r <= div_q;
          endcase
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (which_r == 2'd0) begin
            which_r <= 2'd1; state_r <= S_NORM;
          end else if (which_r == 2'd2) begin
            if (rn_r > rau_pkg::LIMIT || rd_r > rau_pkg::LIMIT) begin
              o_den_r <= '0; o_st_r <= rau_pkg::ST_OVERFLOW;
            end else begin
              o_num_r <= rn_neg_r ? -32'(rn_r) : 32'(rn_r);
              o_den_r <= 31'(rd_r);
            end
            state_r <= S_OUT; out_valid_r <= 1'b1;
          end else begin
            if (op_r == rau_pkg::OP_EQ) begin
              o_cmp_r <= (an_r == cn_r) && (ad_r == cd_r) &&
                         ((an_neg_r == cn_neg_r) || an_r == '0);
              state_r <= S_OUT; out_valid_r <= 1'b1;
            end else if (op_r == rau_pkg::OP_DIV && cn_r == '0) begin
              o_den_r <= '0; o_st_r <= rau_pkg::ST_DIV_ZERO;
              state_r <= S_OUT; out_valid_r <= 1'b1;
            end else if ((an_r > rau_pkg::LIMIT || cn_r > rau_pkg::LIMIT) &&
                         op_r != rau_pkg::OP_LT) begin
              o_den_r <= '0; o_st_r <= rau_pkg::ST_OVERFLOW;
              state_r <= S_OUT; out_valid_r <= 1'b1;
            end else begin
              state_r <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          p1_r <= rau_pkg::wide_t'(prod);
          p1_neg_r <= an_neg_r && an_r != '0;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          p2_r <= rau_pkg::wide_t'(prod);
          p2_neg_r <= cn_neg_r && cn_r != '0;
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          unique case (op_r)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
              rn_neg_r <= sres[W+1];
              rn_r <= sres[W+1] ? rau_pkg::wide_t'(-sres) : rau_pkg::wide_t'(sres);
              rd_r <= rau_pkg::wide_t'(prod);
              which_r <= 2'd2; state_r <= S_NORM;
            end
            rau_pkg::OP_MUL: begin
              rn_neg_r <= an_neg_r ^ cn_neg_r;
              rn_r <= p1_r;
              rd_r <= rau_pkg::wide_t'(prod);
              which_r <= 2'd2; state_r <= S_NORM;
            end
            rau_pkg::OP_DIV: begin
              rn_neg_r <= an_neg_r ^ cn_neg_r;
              rn_r <= p1_r;
              rd_r <= p2_r;
              which_r <= 2'd2; state_r <= S_NORM;
            end
            default: begin
              o_cmp_r <= s1 < s2;
              state_r <= S_OUT; out_valid_r <= 1'b1;
            end
          endcase
        end
        S_OUT: if (!out_stall) begin
          out_valid_r <= 1'b0; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_result_num = o_num_r;
  assign out_result_den = o_den_r;
  assign out_compare_true = o_cmp_r;
  assign out_status = o_st_r;

`ifndef NO_ASSERTIONS
  a_out_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("valid outside output state");
  a_ok_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rau_pkg::ST_OK |-> out_result_num == '0 && !out_compare_true)
    else $error("error word has payload");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("ready while busy");
`endif

endmodule

/* verif/tb_top.sv */
module tb_top;

  typedef logic signed [65:0] wint_t;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               cmp;
    logic [1:0]         st;
  } frac_res_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] ln;
    logic [31:0] ld;
    logic [31:0] rn;
    logic [31:0] rd;
    bit          typed;
    frac_res_t   res;
  } frac_row_t;

  localparam wint_t WORD_LIM = wint_t'(rau_pkg::LIMIT);
  localparam int unsigned N_RANDOM = 880;
  localparam int unsigned N_DIRECTED = 19;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_req_type = '0;
  logic signed [31:0] in_left_num = '0;
  logic signed [31:0] in_left_den = '0;
  logic signed [31:0] in_right_num = '0;
  logic signed [31:0] in_right_den = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_result_num;
  logic [30:0] out_result_den;
  logic out_compare_true;
  logic [1:0] out_status;

  frac_res_t expected_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_results = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  rational_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_left_num(in_left_num),
    .in_left_den(in_left_den), .in_right_num(in_right_num),
    .in_right_den(in_right_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_num(out_result_num), .out_result_den(out_result_den),
    .out_compare_true(out_compare_true), .out_status(out_status)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic wint_t mag_of(wint_t v);
    return v < 0 ? -v : v;
  endfunction

  function automatic wint_t gcd_of(wint_t x, wint_t y);
    wint_t t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic void reduce_frac(inout wint_t n, inout wint_t d);
    wint_t g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    g = gcd_of(mag_of(n), d);
    if (g == 0) g = 1;
    n = n / g;
    d = d / g;
  endfunction

  function automatic bit in_word(wint_t v);
    return v >= -WORD_LIM && v <= WORD_LIM;
  endfunction

  function automatic frac_res_t predict_fraction(logic [2:0] op, logic [31:0] ln,
                                                 logic [31:0] ld, logic [31:0] rn,
                                                 logic [31:0] rd);
    wint_t a, b, c, d, pn, pd;
    frac_res_t r;
    a = wint_t'($signed(ln));
    b = wint_t'($signed(ld));
    c = wint_t'($signed(rn));
    d = wint_t'($signed(rd));
    pn = 0;
    pd = 1;
    r.cmp = 0;
    r.st = rau_pkg::ST_OK;
    if (op <= rau_pkg::OP_EQ) begin
      if (b == 0 || d == 0) begin
        r.st = rau_pkg::ST_ZERO_DEN;
      end else begin
        reduce_frac(a, b);
        reduce_frac(c, d);
        if (op == rau_pkg::OP_LT) begin
          r.cmp = (a * d < c * b);
        end else if (op == rau_pkg::OP_EQ) begin
          r.cmp = (a == c && b == d);
        end else if (op == rau_pkg::OP_DIV && c == 0) begin
          r.st = rau_pkg::ST_DIV_ZERO;
        end else if (!in_word(a) || !in_word(c)) begin
          r.st = rau_pkg::ST_OVERFLOW;
        end else begin
          case (op)
            rau_pkg::OP_ADD: begin pn = a * d + c * b; pd = b * d; end
            rau_pkg::OP_SUB: begin pn = a * d - c * b; pd = b * d; end
            rau_pkg::OP_MUL: begin pn = a * c; pd = b * d; end
            default: begin pn = a * d; pd = b * c; end
          endcase
          reduce_frac(pn, pd);
          if (!in_word(pn) || !in_word(pd)) r.st = rau_pkg::ST_OVERFLOW;
        end
      end
    end
    if (r.st != rau_pkg::ST_OK) begin
      pn = 0;
      pd = 0;
      r.cmp = 0;
    end
    r.num = pn[31:0];
    r.den = pd[30:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("MISMATCH result %0d %s: got %0d want %0d", n_results, what, got, want);
  endtask

  always @(posedge clk) begin
    frac_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = expected_q.pop_front();
          status_seen[out_status]++;
          if (out_result_num !== want.num)
            report_mismatch("result_num", out_result_num, want.num);
          if (out_result_den !== want.den)
            report_mismatch("result_den", out_result_den, want.den);
          if (out_compare_true !== want.cmp)
            report_mismatch("compare_true", out_compare_true, want.cmp);
          if (out_status !== want.st)
            report_mismatch("status", out_status, want.st);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_word(logic [2:0] op, logic [31:0] ln, logic [31:0] ld,
                           logic [31:0] rn, logic [31:0] rd, bit typed, frac_res_t res);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= op;
    in_left_num <= ln;
    in_left_den <= ld;
    in_right_num <= rn;
    in_right_den <= rd;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(typed ? res : predict_fraction(op, ln, ld, rn, rd));
    n_sent++;
  endtask

  function automatic logic [31:0] pick_value(bit is_den);
    int unsigned k;
    logic [31:0] v;
    k = $urandom_range(99);
    if (is_den && k < 4) return 32'd0;
    if (k < 30) return 32'($signed($urandom_range(200)) - 100);
    if (k < 50) return 32'($signed($urandom_range(131070)) - 65535);
    if (k < 65) begin
      v = 32'($urandom_range(1, 60) * $urandom_range(1, 60) * $urandom_range(1, 40));
      return ($urandom_range(1) != 0) ? -v : v;
    end
    if (k < 75) begin
      case ($urandom_range(5))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h8000_0001;
        3: return 32'h0000_0001;
        4: return 32'hFFFF_FFFF;
        default: return is_den ? 32'h0000_0002 : 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  frac_row_t directed[N_DIRECTED] = '{
    '{rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1,
      '{32'sd5, 31'd6, 1'b0, rau_pkg::ST_OK}},
    '{rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd2, 32'd4, 1,
      '{32'sd0, 31'd1, 1'b0, rau_pkg::ST_OK}},
    '{rau_pkg::OP_MUL, -32'd2, 32'd4, 32'd3, -32'd9, 1,
      '{32'sd1, 31'd6, 1'b0, rau_pkg::ST_OK}},
    '{rau_pkg::OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5, 1,
      '{32'sd0, 31'd0, 1'b0, rau_pkg::ST_DIV_ZERO}},
    '{rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1, 1,
      '{32'sd0, 31'd0, 1'b0, rau_pkg::ST_ZERO_DEN}},
    '{rau_pkg::OP_LT, 32'd1, 32'd1, 32'd1, 32'd0, 1,
      '{32'sd0, 31'd0, 1'b0, rau_pkg::ST_ZERO_DEN}},
    '{rau_pkg::OP_LT, 32'd1, 32'd3, 32'd1, 32'd2, 1,
      '{32'sd0, 31'd1, 1'b1, rau_pkg::ST_OK}},
    '{rau_pkg::OP_EQ, 32'd2, 32'd4, -32'd1, -32'd2, 1,
      '{32'sd0, 31'd1, 1'b1, rau_pkg::ST_OK}},
    '{rau_pkg::OP_EQ, 32'd0, 32'd7, 32'd0, -32'd3, 1,
      '{32'sd0, 31'd1, 1'b1, rau_pkg::ST_OK}},
    '{3'd6, 32'd5, 32'd0, 32'd1, 32'd0, 1, '{32'sd0, 31'd1, 1'b0, rau_pkg::ST_OK}},
    '{3'd7, 32'hFFFF_FFFF, 32'd3, 32'd9, 32'd2, 1,
      '{32'sd0, 31'd1, 1'b0, rau_pkg::ST_OK}},
    '{rau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 1,
      '{32'sd0, 31'd0, 1'b0, rau_pkg::ST_OVERFLOW}},
    '{rau_pkg::OP_ADD, 32'h8000_0000, 32'd1, 32'd0, 32'd1, 1,
      '{32'sd0, 31'd0, 1'b0, rau_pkg::ST_OVERFLOW}},
    '{rau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
      '{32'sd1, 31'd1, 1'b0, rau_pkg::ST_OK}},
    '{rau_pkg::OP_LT, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1, 0,
      '{0, 0, 0, 0}},
    '{rau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0001, 32'h7FFF_FFFF, 0,
      '{0, 0, 0, 0}},
    '{rau_pkg::OP_SUB, 32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0,
      '{0, 0, 0, 0}},
    '{rau_pkg::OP_DIV, 32'd6, 32'h8000_0000, -32'd3, 32'd7, 0, '{0, 0, 0, 0}},
    '{rau_pkg::OP_EQ, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1, 0, '{0, 0, 0, 0}}
  };

  initial begin
    logic [2:0] op;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    send_idle_pct = 14;
    recv_idle_pct = 68;
    foreach (directed[i])
      send_word(directed[i].op, directed[i].ln, directed[i].ld, directed[i].rn,
                directed[i].rd, directed[i].typed, directed[i].res);
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 14;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      op = ($urandom_range(99) < 3) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_word(op, pick_value(0), pick_value(1), pick_value(0), pick_value(1), 0,
                '{0, 0, 0, 0});
    end
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("sent %0d words, checked %0d results", n_sent, n_results);
    $display("status ok %0d, zero den %0d, div by zero %0d, overflow %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (n_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
